### rtl/ucn_pkg.sv
package ucn_pkg;

  // component selector codes
  localparam logic [2:0] COMP_SCHEME   = 3'd0;
  localparam logic [2:0] COMP_USERINFO = 3'd1;
  localparam logic [2:0] COMP_HOST     = 3'd2;
  localparam logic [2:0] COMP_PORT     = 3'd3;
  localparam logic [2:0] COMP_PATH     = 3'd4;
  localparam logic [2:0] COMP_QUERY    = 3'd5;
  localparam logic [2:0] COMP_FRAGMENT = 3'd6;
  localparam logic [2:0] COMP_NONE     = 3'd7;

  // result status codes
  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_BAD_ESC  = 2'd1;
  localparam logic [1:0] ST_RESERVED = 2'd2;

  // escape decoder phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CASE_BIT    = 8'h20;
  localparam logic [7:0] IPV6_CLASS  = 8'h80;

  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic [2:0] component;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_end;
    logic       string_end;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    logic [7:0] l;
    l = c | CASE_BIT;
    return is_digit(c) || (l >= 8'h61 && l <= 8'h66);
  endfunction

  // only meaningful for a hex digit; letters fold to low nibble + 9
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    return is_digit(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h37 + {4'd0, v};
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | CASE_BIT) : c;
  endfunction

  // bit k: allowed in component k; bit 7: IPv6 host literal
  function automatic logic [7:0] class_bits(input logic [7:0] c);
    logic dig, alp, unres, sub, pchar;
    logic [7:0] m;
    dig   = is_digit(c);
    alp   = is_alpha(c);
    unres = dig || alp || c == 8'h2D || c == 8'h2E || c == 8'h5F || c == 8'h7E;
    sub   = c == 8'h21 || c == 8'h24 || (c >= 8'h26 && c <= 8'h2C)
            || c == 8'h3B || c == 8'h3D;
    pchar = unres || sub || c == 8'h3A || c == 8'h40;
    m[0] = dig || alp || c == 8'h2D || c == 8'h2E || c == 8'h2B;
    m[1] = unres || sub || c == 8'h3A;
    m[2] = unres || sub;
    m[3] = dig;
    m[4] = pchar || c == 8'h2F;
    m[5] = pchar || c == 8'h2F || c == 8'h3F;
    m[6] = m[5];
    m[7] = is_xdigit(c) || c == 8'h5B || c == 8'h5D || c == 8'h3A || c == 8'h2E;
    return c[7] ? 8'h00 : m;
  endfunction

endpackage

### rtl/uri_component_normalizer_unit.sv
// Normalises URI component strings one byte at a time. A request carries one
// raw byte with its component kind and a first-byte flag in tuser; tlast marks
// the final byte of the string. Each byte gives zero to three results: a
// decoded or passed byte, an uppercase %XX re-encoding, or a single error
// (zero data, status in tuser) after which the string stays silent until the
// next first byte. Bytes pass through the input register and the result
// register. A new byte is taken every cycle while each gives at most one
// result and the output is not stalled; a re-encoded escape holds the single
// result port until its last result is taken. An input register lets the
// next byte be taken while a result still waits downstream.
module uri_component_normalizer_unit
  import ucn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic [3:0] s_tuser,   // [2:0] component, [3] first_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser,   // [1:0] status, [2] run_end
  output logic       m_tlast    // string_end
);

  logic       in_valid;
  in_item_t   in_q;
  logic [1:0] cnt;
  result_t    res_q [MAX_RESULTS];

  logic [1:0] escape_phase, escape_phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       ipv6_host, ipv6_host_next;
  logic       failed, failed_next;

  result_t    res_next [MAX_RESULTS];
  logic [1:0] n_next;
  logic       proc;

  logic [7:0] mask;
  logic       lower;
  logic [1:0] err;
  logic [7:0] dec;
  logic [7:0] b;

  assign b    = in_q.in_byte;
  assign proc = in_valid && (cnt == 2'd0 || (cnt == 2'd1 && m_tready));
  assign s_tready = !in_valid || proc;

  always_comb begin
    escape_phase_next = escape_phase;
    high_nibble_next  = high_nibble;
    ipv6_host_next    = ipv6_host;
    failed_next       = failed;
    n_next = 2'd0;
    err    = ST_DATA;
    mask   = 8'h00;
    lower  = 1'b0;
    dec    = {high_nibble, hex_value(b)};
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_next[i] = '0;
    end

    if (in_q.first_byte) begin
      escape_phase_next = PH_IDLE;
      high_nibble_next  = 4'd0;
      failed_next       = 1'b0;
      ipv6_host_next    = (in_q.component == COMP_HOST) && (b == CH_LBRACKET);
    end
    dec = {high_nibble_next, hex_value(b)};

    if (failed_next) begin
      if (in_q.last_byte) begin
        escape_phase_next = PH_IDLE;
      end
    end else begin
      if (ipv6_host_next && in_q.component == COMP_HOST) begin
        mask = IPV6_CLASS;
      end else if (in_q.component != COMP_NONE) begin
        mask = 8'd1 << in_q.component;
      end
      lower = (in_q.component == COMP_SCHEME) || (in_q.component == COMP_HOST);

      if (escape_phase_next == PH_PCT) begin
        if (is_xdigit(b)) begin
          high_nibble_next  = hex_value(b);
          escape_phase_next = PH_HIGH;
        end else begin
          err = ST_BAD_ESC;
        end
      end else if (escape_phase_next == PH_HIGH) begin
        if (is_xdigit(b)) begin
          escape_phase_next = PH_IDLE;
          if (|(class_bits(dec) & mask)) begin
            res_next[0].out_byte = lower ? to_lower(dec) : dec;
            n_next = 2'd1;
          end else begin
            res_next[0].out_byte = CH_PERCENT;
            res_next[1].out_byte = hex_char(dec[7:4]);
            res_next[2].out_byte = hex_char(dec[3:0]);
            n_next = 2'd3;
          end
        end else begin
          err = ST_BAD_ESC;
        end
      end else begin
        // idle, and the phase that never arises
        escape_phase_next = PH_IDLE;
        if (|(class_bits(b) & mask)) begin
          res_next[0].out_byte = lower ? to_lower(b) : b;
          n_next = 2'd1;
        end else if (b == CH_PERCENT) begin
          escape_phase_next = PH_PCT;
        end else begin
          err = ST_RESERVED;
        end
      end

      // string ends inside an open escape
      if (err == ST_DATA && in_q.last_byte && escape_phase_next != PH_IDLE) begin
        err = ST_BAD_ESC;
      end
      if (err != ST_DATA) begin
        res_next[0].out_byte = 8'h00;
        res_next[0].status   = err;
        n_next            = 2'd1;
        failed_next       = 1'b1;
        escape_phase_next = PH_IDLE;
      end
      if (in_q.last_byte) begin
        escape_phase_next = PH_IDLE;
      end
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_next[i].run_end    = (2'(i) == n_next - 2'd1);
      res_next[i].string_end = (2'(i) == n_next - 2'd1) && in_q.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      cnt          <= 2'd0;
      escape_phase <= PH_IDLE;
      high_nibble  <= 4'd0;
      ipv6_host    <= 1'b0;
      failed       <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (proc) begin
        in_valid <= 1'b0;
      end
      if (proc) begin
        cnt          <= n_next;
        escape_phase <= escape_phase_next;
        high_nibble  <= high_nibble_next;
        ipv6_host    <= ipv6_host_next;
        failed       <= failed_next;
      end else if (m_tvalid && m_tready) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q <= '{in_byte: s_tdata, component: s_tuser[2:0],
                first_byte: s_tuser[3], last_byte: s_tlast};
    end
    if (proc) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_q[i] <= res_next[i];
      end
    end else if (m_tvalid && m_tready) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = res_q[0].out_byte;
  assign m_tuser  = {res_q[0].run_end, res_q[0].status};
  assign m_tlast  = res_q[0].string_end;

endmodule

### rtl/ucn_checker.sv
module ucn_checker
  import ucn_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic [3:0] s_tuser,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  // string end only on the last result of a request
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[2])
    else $error("string end without run end");

  // errors carry zero data and close the run
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != ST_DATA |-> m_tdata == 8'h00 && m_tuser[2])
    else $error("error result malformed");

  // with nothing pending downstream the input side never stalls
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind uri_component_normalizer_unit ucn_checker u_ucn_checker (.*);
